[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks of the circle rasteriser.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising edge, ignored during reset.
`define MCR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define MCR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/mcr_pkg.sv]
// ----------------------------------------------------------------------------
// mcr_pkg
// Types and constants shared by the circle rasteriser modules.
// ----------------------------------------------------------------------------
package mcr_pkg;

	localparam int COLOR_W  = 16;
	localparam int CFG_W    = 11;
	localparam int CFG_IDX_W = 1;
	localparam int NPOINT   = 8;
	localparam int PT_IDX_W = $clog2(NPOINT);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'd1;

	localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 11'd240;
	localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 11'd320;

	// action codes
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_STEP  = 1'b1;

	// midpoint decision constants
	localparam int D_INIT      = 3;
	localparam int D_INC_MINOR = 6;
	localparam int D_INC_MAJOR = 10;

	// what a loaded run of results is
	typedef struct packed {
		logic pixels;    // eight octant pixels, else one status item
		logic rejected;
		logic done;      // finished / nothing active
	} mcr_ctl_t;

	// result flags, point_valid in bit 0
	typedef struct packed {
		logic done_res;
		logic rejected;
		logic point_valid;
	} mcr_flags_t;

	localparam int FLAG_W = $bits(mcr_flags_t);

endpackage

[hdl/mcr_emitter.sv]
// ----------------------------------------------------------------------------
// mcr_emitter
// Holds one step's snapshot and emits its results through an output register.
// ----------------------------------------------------------------------------
module mcr_emitter import mcr_pkg::*; #(
	parameter int CB = 10,
	localparam int OW = ((2 * CB + COLOR_W + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  mcr_ctl_t           ctl,
	input  logic [CB-1:0]      cx,
	input  logic [CB-1:0]      cy,
	input  logic [CB-1:0]      a,
	input  logic [CB-1:0]      b,
	input  logic [COLOR_W-1:0] color,
	output logic               free,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OW-1:0]      m_tdata,   // point_x, point_y, pixel_color
	output logic [FLAG_W-1:0]  m_tuser,   // point_valid, rejected, done_res
	output logic               m_tlast
);

	logic                busy_q;
	mcr_ctl_t            ctl_q;
	logic [PT_IDX_W-1:0] cnt_q;
	logic [CB-1:0]       cx_q, cy_q, a_q, b_q;
	logic [COLOR_W-1:0]  col_q;

	logic                m_valid_q;
	logic [CB-1:0]       px_q, py_q;
	logic [COLOR_W-1:0]  pcol_q;
	mcr_flags_t          flags_q;
	logic                last_q;

	logic                out_load;
	logic                run_last;
	logic [CB-1:0]       offx, offy, px, py;
	mcr_flags_t          flags;

	assign out_load = !m_valid_q || m_tready;
	assign run_last = !ctl_q.pixels || (cnt_q == PT_IDX_W'(NPOINT - 1));
	assign free     = !busy_q || (out_load && run_last);

	// octant select: bit 2 swaps offsets, bit 0 mirrors x, bit 1 mirrors y
	always_comb begin
		offx = cnt_q[2] ? a_q : b_q;
		offy = cnt_q[2] ? b_q : a_q;
		px   = cnt_q[0] ? (cx_q - offx) : (cx_q + offx);
		py   = cnt_q[1] ? (cy_q - offy) : (cy_q + offy);
		flags.point_valid = ctl_q.pixels;
		flags.rejected    = ctl_q.rejected;
		flags.done_res    = ctl_q.done && run_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			ctl_q     <= '0;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_valid_q <= busy_q;
				if (busy_q) begin
					cnt_q <= cnt_q + PT_IDX_W'(1);
					if (run_last)
						busy_q <= 1'b0;
				end
			end
			if (load) begin
				busy_q <= 1'b1;
				ctl_q  <= ctl;
				cnt_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cx_q  <= cx;
			cy_q  <= cy;
			a_q   <= a;
			b_q   <= b;
			col_q <= color;
		end
		if (out_load && busy_q) begin
			px_q    <= ctl_q.pixels ? px : '0;
			py_q    <= ctl_q.pixels ? py : '0;
			pcol_q  <= ctl_q.pixels ? col_q : '0;
			flags_q <= flags;
			last_q  <= run_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OW'({pcol_q, py_q, px_q});
	assign m_tuser  = flags_q;
	assign m_tlast  = last_q;

endmodule

[hdl/midpoint_circle_rasterizer.sv]
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer
// Midpoint circle rasteriser: start and step items in, pixel items out.
//
// A start item (tuser 0) loads centre, radius and colour; the circle is refused
// when any extent falls off a screen of screen_width x screen_height (capped at
// 2^COORD_BITS), giving one item with rejected and done_res set. An accepted
// start gives one status item. Each step item (tuser 1) gives the eight octant
// pixels of the current offsets, tlast on the eighth, which also carries
// done_res once the circle is finished; a step with no circle active gives one
// item with done_res set. Every item ends its run with tlast. Items pass an
// input register, where the circle state is updated, into a result
// serialiser, whose output register emits one result per cycle while m_tready
// is high; the next item is taken as the last result of the previous one
// enters the output register. Screen size must be written only while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module midpoint_circle_rasterizer import mcr_pkg::*; #(
	parameter int COORD_BITS = 10,
	localparam int IN_W  = ((3 * COORD_BITS + COLOR_W + 7) / 8) * 8,
	localparam int OUT_W = ((2 * COORD_BITS + COLOR_W + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	// item in
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_W-1:0]      s_tdata,   // center_x, center_y, radius, color
	input  logic                 s_tuser,   // action
	// results out
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata,   // point_x, point_y, pixel_color
	output logic [FLAG_W-1:0]    m_tuser,   // point_valid, rejected, done_res
	output logic                 m_tlast
);

	localparam int CB = COORD_BITS;
	localparam int LW = (CB + 1 > CFG_W) ? CB + 1 : CFG_W;  // limit compare width
	localparam int DW = CB + 6;                             // decision width

	// screen size registers
	logic [CFG_W-1:0] width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SCREEN_WIDTH_RST;
			height_q <= SCREEN_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SCREEN_WIDTH:  width_q  <= cfg_data;
				CFG_SCREEN_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	logic               valid_s1;
	logic               action_s1;
	logic [CB-1:0]      x_s1, y_s1, r_s1;
	logic [COLOR_W-1:0] color_s1;
	logic               take;
	logic               emit_free;

	assign take     = valid_s1 && emit_free;
	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1 <= s_tuser;
			x_s1      <= s_tdata[CB-1:0];
			y_s1      <= s_tdata[2*CB-1:CB];
			r_s1      <= s_tdata[3*CB-1:2*CB];
			color_s1  <= s_tdata[3*CB+COLOR_W-1:3*CB];
		end
	end

	// circle state
	logic               active_q;
	logic [CB-1:0]      cx_q, cy_q, a_q, b_q;
	logic signed [DW-1:0] d_q;
	logic [COLOR_W-1:0] col_q;

	// on-screen check: x - r >= 0 and x + r <= limit - 1
	logic [LW-1:0]  cap, lim_x, lim_y;
	logic [CB:0]    sum_x, sum_y;
	logic           reject;

	always_comb begin
		cap    = LW'(1) << CB;
		lim_x  = (LW'(width_q)  < cap) ? LW'(width_q)  : cap;
		lim_y  = (LW'(height_q) < cap) ? LW'(height_q) : cap;
		sum_x  = {1'b0, x_s1} + {1'b0, r_s1};
		sum_y  = {1'b0, y_s1} + {1'b0, r_s1};
		reject = (x_s1 < r_s1) || (y_s1 < r_s1)
			|| ((LW + 1)'(sum_x) >= (LW + 1)'(lim_x))
			|| ((LW + 1)'(sum_y) >= (LW + 1)'(lim_y));
	end

	// midpoint update from the old offsets
	logic signed [DW-1:0]   d_init, d_next, a4, b4;
	logic [CB:0]            a_next;
	logic signed [CB+1:0]   b_next;
	logic                   fin;

	always_comb begin
		d_init = DW'(D_INIT) - (DW'(r_s1) << 1);
		a4     = DW'(a_q) << 2;
		b4     = DW'(b_q) << 2;
		if (d_q < 0) begin
			d_next = d_q + a4 + DW'(D_INC_MINOR);
			b_next = $signed({2'b00, b_q});
		end else begin
			d_next = d_q + a4 - b4 + DW'(D_INC_MAJOR);
			b_next = $signed({2'b00, b_q}) - (CB + 2)'(1);
		end
		a_next = {1'b0, a_q} + (CB + 1)'(1);
		fin    = $signed({1'b0, a_next}) > b_next;
	end

	mcr_ctl_t ctl;

	always_comb begin
		ctl = '0;
		if (action_s1 == ACT_START) begin
			ctl.rejected = reject;
			ctl.done     = reject;
		end else if (!active_q) begin
			ctl.done = 1'b1;
		end else begin
			ctl.pixels = 1'b1;
			ctl.done   = fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			active_q <= 1'b0;
		else if (take) begin
			if (action_s1 == ACT_START)
				active_q <= !reject;
			else if (active_q && fin)
				active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (action_s1 == ACT_START) begin
				if (!reject) begin
					cx_q  <= x_s1;
					cy_q  <= y_s1;
					a_q   <= '0;
					b_q   <= r_s1;
					d_q   <= d_init;
					col_q <= color_s1;
				end
			end else if (active_q) begin
				d_q <= d_next;
				a_q <= a_next[CB-1:0];
				b_q <= b_next[CB+1] ? '0 : b_next[CB-1:0];
			end
		end
	end

	// result serialiser; takes the offsets as they were before this step
	mcr_emitter #(
		.CB(CB)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (take),
		.ctl      (ctl),
		.cx       (cx_q),
		.cy       (cy_q),
		.a        (a_q),
		.b        (b_q),
		.color    (col_q),
		.free     (emit_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// checks
	`MCR_ASSERT_IMPL(a_le_b_a, clk, arst_n, active_q, a_q <= b_q, "active circle has a > b")
	`MCR_ASSERT_IMPL(status_last_a, clk, arst_n, m_tvalid && !m_tuser[0], m_tlast, "status item without last")
	`MCR_ASSERT_NEXT(start_active_a, clk, arst_n, take && action_s1 == ACT_START && !reject, active_q, "accepted start left block idle")

endmodule
